### design/indexed_list_store_macros.svh
// Assertion macros used by the indexed list store checker
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ILS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ils_pkg.sv
// Shared types, field widths and codes for the indexed list store
`default_nettype none

package ils_pkg;

    // Default sizing
    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Field widths of the stream words
    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    localparam int IN_FIELDS_W  = KIND_W + POS_W + ITEM_W;
    localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + ITEM_W + LEN_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Command kinds as they arrive on the input stream
    localparam logic [KIND_W-1:0] KIND_SET    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GET    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_LENGTH = 3'd6;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BOUNDS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd3;

    // Decoded operation handed to the datapath
    typedef enum logic [2:0] {
        OP_SET    = 3'd0,
        OP_INSERT = 3'd1,
        OP_APPEND = 3'd2,
        OP_GET    = 3'd3,
        OP_REMOVE = 3'd4,
        OP_POP    = 3'd5,
        OP_REPORT = 3'd6
    } op_t;

    // Controller to datapath command
    typedef struct packed {
        logic exec;
        op_t  op;
    } cmd_t;

endpackage

`default_nettype wire

### design/ils_ctrl.sv
// Controller: input/output handshake and command decode
`default_nettype none

module ils_ctrl
    import ils_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [KIND_W-1:0] kind,
    output logic              m_tvalid,
    input  logic              m_tready,
    output cmd_t              cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   exec;

    // Result slot is free, or being emptied this cycle
    assign s_tready = (state_reg == ST_IDLE) || m_tready;
    assign m_tvalid = (state_reg == ST_HOLD);
    assign exec     = s_tvalid && s_tready;

    // Kind decode; length and the unused code only report
    always_comb
    begin
        cmd.exec = exec;
        case (kind)
            KIND_SET:    cmd.op = OP_SET;
            KIND_INSERT: cmd.op = OP_INSERT;
            KIND_APPEND: cmd.op = OP_APPEND;
            KIND_GET:    cmd.op = OP_GET;
            KIND_REMOVE: cmd.op = OP_REMOVE;
            KIND_POP:    cmd.op = OP_POP;
            KIND_LENGTH: cmd.op = OP_REPORT;
            default:     cmd.op = OP_REPORT;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (exec)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (exec)
                begin
                    state_next = ST_HOLD;
                end
                else if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### design/ils_datapath.sv
// Datapath: row of entry cells, length counter and result register
`default_nettype none

module ils_datapath
    import ils_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [POS_W-1:0]    position,
    input  logic [ITEM_W-1:0]   item_value,
    output logic [STATUS_W-1:0] status,
    output logic [ITEM_W-1:0]   read_value,
    output logic [LEN_W-1:0]    length_now
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;
    localparam int WW = (VALUE_BITS > ITEM_W) ? VALUE_BITS : ITEM_W;
    localparam logic [IW-1:0] CAP_W = IW'(CAPACITY);

    logic [VALUE_BITS-1:0] cells_reg  [CAPACITY];
    logic [VALUE_BITS-1:0] cells_next [CAPACITY];
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [ITEM_W-1:0]     read_reg;
    logic [LEN_W-1:0]      len_reg;

    logic [IW-1:0]         pos_w;
    logic [IW-1:0]         cnt_w;
    logic [IW-1:0]         last_w;
    logic [IW-1:0]         wr_idx;
    logic [IW-1:0]         rd_idx;
    logic [IW-1:0]         len_w;
    logic                  full;
    logic                  empty;
    logic                  wr_en;
    logic                  shift_up;
    logic                  shift_dn;
    logic                  take;
    logic                  cnt_up;
    logic                  cnt_dn;
    logic [STATUS_W-1:0]   st;
    logic [WW-1:0]         in_wide;
    logic [VALUE_BITS-1:0] store_val;
    logic [VALUE_BITS-1:0] rd_cell;
    logic [WW-1:0]         rd_wide;

    assign pos_w  = IW'(position);
    assign cnt_w  = IW'(count_reg);
    assign last_w = cnt_w - IW'(1);
    assign full   = (cnt_w == CAP_W);
    assign empty  = (count_reg == '0);

    // Value masked to the stored width
    assign in_wide   = WW'(item_value);
    assign store_val = in_wide[VALUE_BITS-1:0];

    // Single read port: position, or the last entry for pop
    assign rd_cell = cells_reg[rd_idx[AW-1:0]];
    assign rd_wide = WW'(rd_cell);

    // Operation decode into cell controls and status
    always_comb
    begin
        st       = STATUS_OK;
        wr_en    = 1'b0;
        shift_up = 1'b0;
        shift_dn = 1'b0;
        take     = 1'b0;
        cnt_up   = 1'b0;
        cnt_dn   = 1'b0;
        wr_idx   = pos_w;
        rd_idx   = pos_w;
        case (cmd.op)
            OP_SET:
            begin
                if (pos_w > cnt_w)
                begin
                    st = STATUS_BOUNDS;
                end
                else if ((pos_w == cnt_w) && full)
                begin
                    st = STATUS_FULL;
                end
                else
                begin
                    wr_en  = 1'b1;
                    cnt_up = (pos_w == cnt_w);
                end
            end
            OP_INSERT:
            begin
                if (pos_w > cnt_w)
                begin
                    st = STATUS_BOUNDS;
                end
                else if (full)
                begin
                    st = STATUS_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    shift_up = 1'b1;
                    cnt_up   = 1'b1;
                end
            end
            OP_APPEND:
            begin
                wr_idx = cnt_w;
                if (full)
                begin
                    st = STATUS_FULL;
                end
                else
                begin
                    wr_en  = 1'b1;
                    cnt_up = 1'b1;
                end
            end
            OP_GET:
            begin
                if (pos_w >= cnt_w)
                begin
                    st = STATUS_BOUNDS;
                end
                else
                begin
                    take = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos_w >= cnt_w)
                begin
                    st = STATUS_BOUNDS;
                end
                else
                begin
                    take     = 1'b1;
                    shift_dn = 1'b1;
                    cnt_dn   = 1'b1;
                end
            end
            OP_POP:
            begin
                rd_idx = last_w;
                if (empty)
                begin
                    st = STATUS_EMPTY;
                end
                else
                begin
                    take   = 1'b1;
                    cnt_dn = 1'b1;
                end
            end
            OP_REPORT:
            begin
                st = STATUS_OK;
            end
            default:
            begin
                st = STATUS_OK;
            end
        endcase
    end

    // Each cell takes its lower or upper neighbour, or the new value
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cells_next[i] = cells_reg[i];
            if ((i > 0) && shift_up && (IW'(i) > pos_w))
            begin
                cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
            end
            else if ((i < CAPACITY - 1) && shift_dn && (IW'(i) >= pos_w))
            begin
                cells_next[i] = cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
            if (wr_en && (IW'(i) == wr_idx))
            begin
                cells_next[i] = store_val;
            end
        end
    end

    // New length
    always_comb
    begin
        count_next = count_reg;
        if (cnt_up)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cnt_dn)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign len_w = IW'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    // Cells and result word
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            cells_reg  <= cells_next;
            status_reg <= st;
            read_reg   <= take ? rd_wide[ITEM_W-1:0] : '0;
            len_reg    <= len_w[LEN_W-1:0];
        end
    end

    assign status     = status_reg;
    assign read_value = read_reg;
    assign length_now = len_reg;

endmodule

`default_nettype wire

### design/indexed_list_store.sv
// Top level of the indexed list store
// An ordered list of up to CAPACITY handles held in a row of entry cells.
// Each accepted command word (set, insert, append, get, remove, pop,
// length) is carried out in the cycle it is accepted: the whole row shifts
// at once for insert and remove, so one command can be accepted per cycle
// while the result output is not stalled. The result word (status, value,
// new length) appears on the output in the cycle after acceptance and is
// held in an output register; a new command is accepted whenever that
// register is empty or being taken in the same cycle. No clearing pass
// follows reset; the list starts empty.
`default_nettype none

module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // kind[2:0], position[7:3], item_value[39:8]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[1:0], read_value[33:2], length_now[38:34], 0
);

    cmd_t                cmd;
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    position;
    logic [ITEM_W-1:0]   item_value;
    logic [STATUS_W-1:0] status;
    logic [ITEM_W-1:0]   read_value;
    logic [LEN_W-1:0]    length_now;

    // Unpack the command word
    assign kind       = s_tdata[KIND_W-1:0];
    assign position   = s_tdata[KIND_W +: POS_W];
    assign item_value = s_tdata[KIND_W + POS_W +: ITEM_W];

    ils_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (kind),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ils_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .position   (position),
        .item_value (item_value),
        .status     (status),
        .read_value (read_value),
        .length_now (length_now)
    );

    // Pack the result word, padded to whole bytes
    assign m_tdata = {(OUT_W - OUT_FIELDS_W)'(0), length_now, read_value, status};

endmodule

`default_nettype wire

### design/ils_checker.sv
// Port-level checker for the indexed list store, bound to the top level
`default_nettype none
`include "indexed_list_store_macros.svh"

module ils_checker
    import ils_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata
);

    logic                in_word;
    logic [STATUS_W-1:0] res_status;
    logic [ITEM_W-1:0]   res_value;
    logic [KIND_W-1:0]   in_kind;

    assign in_word    = s_tvalid && s_tready;
    assign in_kind    = s_tdata[KIND_W-1:0];
    assign res_status = m_tdata[STATUS_W-1:0];
    assign res_value  = m_tdata[STATUS_W +: ITEM_W];

    // A stalled result stays offered and unchanged
    `ILS_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `ILS_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

    // Every accepted command produces a result in the next cycle
    `ILS_ASSERT_NEXT(a_result_follows, in_word, m_tvalid, "no result after accepted command")

    // Failed commands never return a value
    `ILS_ASSERT_NOW(a_fail_no_value, m_tvalid && (res_status != STATUS_OK), res_value == '0, "value on failed command")

    // Length reports always succeed
    `ILS_ASSERT_NEXT(a_length_ok, in_word && (in_kind == KIND_LENGTH), res_status == STATUS_OK, "length report failed")

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);

`default_nettype wire

### dv/indexed_list_store_tb.sv
// Self-checking testbench for the indexed list store: directed table, then random commands
`timescale 1ns / 1ps

module indexed_list_store_tb;
    import ils_pkg::*;

    // The one kind code the package leaves unnamed; the block answers it like length
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    localparam int RANDOM_WORDS    = 1260;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;

    // One result word, unpacked
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ITEM_W-1:0]   value;
        logic [LEN_W-1:0]    length;
    } list_result_t;

    // One row of the directed table; typed rows carry their answer, others use the predictor
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [POS_W-1:0]    pos;
        logic [ITEM_W-1:0]   value;
        logic [5:0]          reps;
        logic                typed;
        logic [STATUS_W-1:0] want_status;
        logic [ITEM_W-1:0]   want_value;
        logic [LEN_W-1:0]    want_len;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 27;
    localparam directed_row_t DIRECTED_STEPS [DIRECTED_ROWS] = '{
        // empty list: length reports zero; get, remove, pop and out-of-range writes miss
        '{KIND_LENGTH, 5'd0,  32'h0000_0000, 6'd1,  1'b1, STATUS_OK,     32'h0, 5'd0},
        '{KIND_POP,    5'd0,  32'h0000_0000, 6'd1,  1'b1, STATUS_EMPTY,  32'h0, 5'd0},
        '{KIND_GET,    5'd0,  32'h0000_0000, 6'd1,  1'b1, STATUS_BOUNDS, 32'h0, 5'd0},
        '{KIND_REMOVE, 5'd31, 32'h0000_0000, 6'd1,  1'b1, STATUS_BOUNDS, 32'h0, 5'd0},
        '{KIND_SET,    5'd1,  32'hAAAA_5555, 6'd1,  1'b1, STATUS_BOUNDS, 32'h0, 5'd0},
        '{KIND_INSERT, 5'd31, 32'h5555_AAAA, 6'd1,  1'b1, STATUS_BOUNDS, 32'h0, 5'd0},
        // set at the end appends; insert at the head; zero handle stored and read back
        '{KIND_SET,    5'd0,  32'hFFFF_FFFF, 6'd1,  1'b1, STATUS_OK,     32'h0, 5'd1},
        '{KIND_INSERT, 5'd0,  32'h0000_0001, 6'd1,  1'b1, STATUS_OK,     32'h0, 5'd2},
        '{KIND_APPEND, 5'd0,  32'h0000_0000, 6'd1,  1'b1, STATUS_OK,     32'h0, 5'd3},
        '{KIND_GET,    5'd2,  32'h0000_0000, 6'd1,  1'b1, STATUS_OK,     32'h0, 5'd3},
        '{KIND_GET,    5'd1,  32'h0000_0000, 6'd1,  1'b0, STATUS_OK,     32'h0, 5'd0},
        '{KIND_INSERT, 5'd3,  32'h8000_0000, 6'd1,  1'b0, STATUS_OK,     32'h0, 5'd0},
        '{KIND_UNUSED, 5'd31, 32'hFFFF_FFFF, 6'd1,  1'b1, STATUS_OK,     32'h0, 5'd4},
        '{KIND_REMOVE, 5'd0,  32'h0000_0000, 6'd1,  1'b0, STATUS_OK,     32'h0, 5'd0},
        '{KIND_SET,    5'd2,  32'h1234_5678, 6'd1,  1'b0, STATUS_OK,     32'h0, 5'd0},
        // fill to capacity, then every way of running into a full list
        '{KIND_APPEND, 5'd0,  32'hDEAD_BEEF, 6'd13, 1'b0, STATUS_OK,     32'h0, 5'd0},
        '{KIND_APPEND, 5'd0,  32'h0BAD_F00D, 6'd1,  1'b1, STATUS_FULL,   32'h0, 5'd16},
        '{KIND_INSERT, 5'd0,  32'h0BAD_F00D, 6'd1,  1'b1, STATUS_FULL,   32'h0, 5'd16},
        '{KIND_SET,    5'd16, 32'h0BAD_F00D, 6'd1,  1'b1, STATUS_FULL,   32'h0, 5'd16},
        '{KIND_SET,    5'd31, 32'h0BAD_F00D, 6'd1,  1'b1, STATUS_BOUNDS, 32'h0, 5'd16},
        '{KIND_INSERT, 5'd17, 32'h0BAD_F00D, 6'd1,  1'b1, STATUS_BOUNDS, 32'h0, 5'd16},
        '{KIND_GET,    5'd16, 32'h0000_0000, 6'd1,  1'b1, STATUS_BOUNDS, 32'h0, 5'd16},
        // last cell, tail removal, then shifts in the middle and from the head
        '{KIND_GET,    5'd15, 32'h0000_0000, 6'd1,  1'b0, STATUS_OK,     32'h0, 5'd0},
        '{KIND_REMOVE, 5'd15, 32'h0000_0000, 6'd1,  1'b0, STATUS_OK,     32'h0, 5'd0},
        '{KIND_POP,    5'd0,  32'h0000_0000, 6'd1,  1'b0, STATUS_OK,     32'h0, 5'd0},
        '{KIND_INSERT, 5'd8,  32'h7777_0008, 6'd1,  1'b0, STATUS_OK,     32'h0, 5'd0},
        '{KIND_REMOVE, 5'd0,  32'h0000_0000, 6'd1,  1'b0, STATUS_OK,     32'h0, 5'd0}
    };

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // kind, position, item_value
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // status, read_value, length_now, pad

    // Predictor state: the list as the block should hold it
    logic [ITEM_W-1:0] list_cells [CAPACITY_DEF];
    int unsigned       list_len;

    list_result_t awaited_results [$];

    int  mismatch_count;
    int  command_count;
    int  result_count;
    int  full_hits;
    int  empty_hits;
    int  bounds_hits;
    int  burst_left;
    bit  random_phase;

    indexed_list_store u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Carry out one command on the predicted list and return the word it yields
    function automatic list_result_t apply_list_command(input logic [KIND_W-1:0] kind,
                                                        input logic [POS_W-1:0]  pos,
                                                        input logic [ITEM_W-1:0] value);
        list_result_t res;
        int unsigned  at;
        int unsigned  i;
        res.status = STATUS_OK;
        res.value  = '0;
        at = 32'(pos);
        case (kind)
            KIND_SET, KIND_APPEND:
            begin
                if (kind == KIND_APPEND)
                    at = list_len;
                if (at > list_len)
                    res.status = STATUS_BOUNDS;
                else if (at == list_len && list_len >= CAPACITY_DEF)
                    res.status = STATUS_FULL;
                else
                begin
                    list_cells[at] = value;
                    if (at == list_len)
                        list_len++;
                end
            end
            KIND_INSERT:
            begin
                if (at > list_len)
                    res.status = STATUS_BOUNDS;
                else if (list_len >= CAPACITY_DEF)
                    res.status = STATUS_FULL;
                else
                begin
                    for (i = list_len; i > at; i--)
                        list_cells[i] = list_cells[i-1];
                    list_cells[at] = value;
                    list_len++;
                end
            end
            KIND_GET:
            begin
                if (at >= list_len)
                    res.status = STATUS_BOUNDS;
                else
                    res.value = list_cells[at];
            end
            KIND_REMOVE, KIND_POP:
            begin
                if (kind == KIND_POP)
                    at = (list_len == 0) ? 0 : list_len - 1;
                if (kind == KIND_POP && list_len == 0)
                    res.status = STATUS_EMPTY;
                else if (at >= list_len)
                    res.status = STATUS_BOUNDS;
                else
                begin
                    res.value = list_cells[at];
                    for (i = at; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            end
            default: ;
        endcase
        res.length = list_len[LEN_W-1:0];
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_command(input logic [KIND_W-1:0] kind,
                                                     input logic [POS_W-1:0]  pos,
                                                     input logic [ITEM_W-1:0] value);
        logic [IN_W-1:0] word;
        word = '0;
        word[0 +: KIND_W]              = kind;
        word[KIND_W +: POS_W]          = pos;
        word[KIND_W + POS_W +: ITEM_W] = value;
        return word;
    endfunction

    // Handle values biased towards the extremes and single set bits
    function automatic logic [ITEM_W-1:0] pick_handle();
        logic [ITEM_W-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = '0;
            1:       v = '1;
            2:       v = 32'h1 << $urandom_range(0, ITEM_W - 1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [ITEM_W-1:0] got,
                                   input logic [ITEM_W-1:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one command word, with the sender's burst and gap pattern around it
    task automatic issue_command(input logic [KIND_W-1:0] kind,
                                 input logic [POS_W-1:0]  pos,
                                 input logic [ITEM_W-1:0] value,
                                 input bit                use_typed,
                                 input list_result_t      typed_res);
        list_result_t predicted;
        int           gap;
        if (burst_left == 0)
        begin
            // a third of the bursts follow on with no gap at all
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_command(kind, pos, value);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // accepted at this edge
        predicted = apply_list_command(kind, pos, value);
        awaited_results.push_back(use_typed ? typed_res : predicted);
        burst_left--;
        command_count++;
        case (predicted.status)
            STATUS_FULL:   full_hits++;
            STATUS_EMPTY:  empty_hits++;
            STATUS_BOUNDS: bounds_hits++;
            default: ;
        endcase
    endtask

    // Result checker
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (awaited_results.size() == 0)
                report_mismatch("result word with nothing awaited", m_tdata[ITEM_W-1:0], '0);
            else
            begin
                want = awaited_results.pop_front();
                if (m_tdata[0 +: STATUS_W] !== want.status)
                    report_mismatch("status", ITEM_W'(m_tdata[0 +: STATUS_W]),
                                    ITEM_W'(want.status));
                if (m_tdata[STATUS_W +: ITEM_W] !== want.value)
                    report_mismatch("read_value", m_tdata[STATUS_W +: ITEM_W], want.value);
                if (m_tdata[STATUS_W + ITEM_W +: LEN_W] !== want.length)
                    report_mismatch("length_now", ITEM_W'(m_tdata[STATUS_W + ITEM_W +: LEN_W]),
                                    ITEM_W'(want.length));
            end
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off once random traffic runs
    initial
    begin : receiver
        int pattern;
        int span;
        int j;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (random_phase && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            pattern = $urandom_range(0, 3);
            span    = $urandom_range(4, 64);
            for (j = 0; j < span; j++)
            begin
                case (pattern)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ((j % 3) != 2);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] Timeout: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        list_result_t      typed_res;
        directed_row_t     row;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        bit                growing;
        int                r;
        int                k;
        int                n;
        int                peak_len;

        mismatch_count = 0;
        command_count  = 0;
        result_count   = 0;
        full_hits      = 0;
        empty_hits     = 0;
        bounds_hits    = 0;
        burst_left     = 0;
        random_phase   = 1'b0;
        list_len       = 0;
        peak_len       = 0;
        growing        = 1'b1;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        rst_n    <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = DIRECTED_STEPS[r];
            typed_res.status = row.want_status;
            typed_res.value  = row.want_value;
            typed_res.length = row.want_len;
            for (k = 0; k < row.reps; k++)
                issue_command(row.kind, row.pos, row.value, row.typed, typed_res);
        end

        // Random part: the list swings between growing and shrinking so both ends are hit
        random_phase = 1'b1;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (list_len >= CAPACITY_DEF && $urandom_range(0, 3) != 0)
                growing = 1'b0;
            else if (list_len == 0 && $urandom_range(0, 3) != 0)
                growing = 1'b1;
            else if ($urandom_range(0, 15) == 0)
                growing = !growing;

            r = $urandom_range(0, 99);
            if (growing)
                kind = (r < 15) ? KIND_SET : (r < 50) ? KIND_INSERT : (r < 75) ? KIND_APPEND :
                       (r < 88) ? KIND_GET : (r < 94) ? KIND_REMOVE : (r < 97) ? KIND_POP :
                       KIND_LENGTH;
            else
                kind = (r < 5) ? KIND_SET : (r < 12) ? KIND_INSERT : (r < 20) ? KIND_APPEND :
                       (r < 40) ? KIND_GET : (r < 70) ? KIND_REMOVE : (r < 95) ? KIND_POP :
                       KIND_LENGTH;

            // positions mostly in range for the command; set and insert may hit the end
            if (kind == KIND_SET || kind == KIND_INSERT)
                pos = POS_W'($urandom_range(0, list_len));
            else if (list_len != 0)
                pos = POS_W'($urandom_range(0, list_len - 1));
            else
                pos = '0;

            // noise: any kind, any position
            if ($urandom_range(0, 99) < 8)
            begin
                kind = KIND_W'($urandom_range(0, 7));
                pos  = POS_W'($urandom_range(0, 31));
            end

            issue_command(kind, pos, pick_handle(), 1'b0, typed_res);
            if (list_len > peak_len)
                peak_len = int'(list_len);
        end
        s_tvalid <= 1'b0;

        // Drain, then wait for any stray word
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands and %0d result words; peak length %0d of %0d",
                 command_count, result_count, peak_len, CAPACITY_DEF);
        $display("Error answers: %0d full, %0d empty pop, %0d out of bounds; %0d bad fields",
                 full_hits, empty_hits, bounds_hits, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
